// ===== hdl/fqs_pkg.sv =====
`timescale 1ns / 1ps
package fqs_pkg;
  localparam int unsigned NumLevelsDef = 10;
  localparam int unsigned MaxTasksDef = 16;
  localparam int unsigned IdW = 4;
  localparam int unsigned LenW = 8;
  localparam int unsigned TimeW = 16;

  typedef enum logic {
    KIND_ARRIVE = 1'b0,
    KIND_TICK   = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } back_state_e;

  typedef struct packed {
    logic            kind;
    logic [IdW-1:0]  task_id;
    logic [LenW-1:0] service_len;
  } cmd_t;

  typedef struct packed {
    logic            run_valid;
    logic [IdW-1:0]  run_id;
    logic            done_valid;
    logic [TimeW-1:0] done_time;
  } res_t;
endpackage

// ===== hdl/fqs_if.sv =====
`timescale 1ns / 1ps
interface fqs_in_if import fqs_pkg::*; ();
  logic valid;
  logic ready;
  logic kind;
  logic [IdW-1:0] task_id;
  logic [LenW-1:0] service_len;
  modport source (output valid, kind, task_id, service_len, input ready);
  modport sink (input valid, kind, task_id, service_len, output ready);
endinterface

interface fqs_out_if import fqs_pkg::*; ();
  logic valid;
  logic ready;
  logic run_valid;
  logic [IdW-1:0] run_id;
  logic done_valid;
  logic [TimeW-1:0] done_time;
  modport source (output valid, run_valid, run_id, done_valid, done_time, input ready);
  modport sink (input valid, run_valid, run_id, done_valid, done_time, output ready);
endinterface

// ===== hdl/fqs_ram.sv =====
`timescale 1ns / 1ps
module fqs_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hdl/fqs_front.sv =====
`timescale 1ns / 1ps
module fqs_front import fqs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  fqs_in_if.sink in_i,
  output logic  cmd_valid_o,
  output cmd_t  cmd_o,
  input  logic  cmd_ready_i
);
  // Two-entry queue between the input channel and the scheduler core.
  cmd_t     buf_q [2];
  logic     wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic     push, pop;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = buf_q[rd_q];

  always_comb begin
    wr_d  = push ? ~wr_q : wr_q;
    rd_d  = pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= '{kind: in_i.kind, task_id: in_i.task_id,
                       service_len: in_i.service_len};
    end
  end
endmodule

// ===== hdl/fqs_back.sv =====
`timescale 1ns / 1ps
module fqs_back import fqs_pkg::*; #(
  parameter int unsigned NumLevels = NumLevelsDef,
  parameter int unsigned MaxTasks  = MaxTasksDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_ready_o,
  fqs_out_if.source out_o
);
  localparam int unsigned LvlW  = (NumLevels > 1) ? $clog2(NumLevels) : 1;
  localparam int unsigned SlotW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned SumW  = SlotW + 1;
  localparam int unsigned CntW  = $clog2(MaxTasks + 1);
  localparam int unsigned Depth = NumLevels * MaxTasks;
  localparam int unsigned AddrW = $clog2(Depth);

  back_state_e state_q, state_d;
  logic [SlotW-1:0] head_q [NumLevels];
  logic [CntW-1:0]  count_q [NumLevels];
  logic [LenW-1:0]  served_q [MaxTasks];
  logic [LenW-1:0]  needed_q [MaxTasks];
  logic [LvlW-1:0]  level_q [MaxTasks];
  logic [SlotW-1:0] cur_q;
  logic             cur_valid_q;
  logic [TimeW-1:0] tick_q;
  cmd_t             cmd_q;
  logic             ovalid_q;
  res_t             res_q;

  logic             any_ready;
  logic [LvlW-1:0]  top_lvl;
  logic             we;
  logic [AddrW-1:0] waddr, raddr;
  logic [IdW-1:0]   wdata, rdata;
  logic             id_ok, cur_live;
  logic [LvlW-1:0]  dem_lvl;
  logic [SlotW-1:0] new_cur;
  logic             do_pop, do_push, serve;
  logic [LvlW-1:0]  push_lvl;
  logic [SlotW-1:0] push_id;
  logic [LenW-1:0]  served_nx;
  logic [SlotW-1:0] head_nx;
  logic [SumW-1:0]  wsum;
  logic [SlotW-1:0] wslot;

  always_comb begin
    any_ready = 1'b0;
    top_lvl   = '0;
    for (int l = NumLevels - 1; l >= 0; l--) begin
      if (count_q[l] != '0) begin
        any_ready = 1'b1;
        top_lvl   = LvlW'(l);
      end
    end
  end

  // The read address is presented in ST_READ; data returns in ST_EXEC.
  assign raddr = AddrW'(top_lvl * MaxTasks + head_q[top_lvl]);

  fqs_ram #(.Width(IdW), .Depth(Depth)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign id_ok    = (32'(cmd_q.task_id) < MaxTasks);
  assign cur_live = cur_valid_q && (served_q[cur_q] < needed_q[cur_q]);
  assign dem_lvl  = (32'(level_q[cur_q]) + 1 < NumLevels) ? level_q[cur_q] + 1'b1
                                                          : level_q[cur_q];

  always_comb begin
    do_pop   = 1'b0;
    do_push  = 1'b0;
    push_lvl = '0;
    push_id  = SlotW'(cmd_q.task_id);
    serve    = 1'b0;
    new_cur  = cur_q;
    if (cmd_q.kind == KIND_ARRIVE) begin
      do_push = id_ok;
    end else if (cur_live) begin
      serve = 1'b1;
      if (any_ready) begin
        do_pop   = 1'b1;
        new_cur  = SlotW'(rdata);
        do_push  = 1'b1;
        push_lvl = dem_lvl;
        push_id  = cur_q;
      end
    end else if (any_ready) begin
      do_pop  = 1'b1;
      serve   = 1'b1;
      new_cur = SlotW'(rdata);
    end
  end

  // When the push goes to the level that was just popped, its count and tail
  // slot are taken after the pop.
  logic push_ok;
  logic [CntW-1:0] push_cnt;
  always_comb begin
    push_cnt = count_q[push_lvl];
    if (do_pop && push_lvl == top_lvl) push_cnt = push_cnt - 1'b1;
    push_ok = do_push && (32'(push_cnt) < MaxTasks);
  end

  always_comb begin
    wsum = {1'b0, head_q[push_lvl]} + SumW'(push_cnt) +
           ((do_pop && push_lvl == top_lvl) ? SumW'(1) : SumW'(0));
    wslot = (32'(wsum) >= MaxTasks) ? SlotW'(32'(wsum) - MaxTasks) : SlotW'(wsum);
  end

  assign head_nx = (32'(head_q[top_lvl]) + 1 >= MaxTasks) ? '0
                                                          : head_q[top_lvl] + 1'b1;

  assign we    = (state_q == ST_EXEC) && push_ok;
  assign waddr = AddrW'(push_lvl * MaxTasks + wslot);
  assign wdata = IdW'(push_id);
  assign served_nx = served_q[new_cur] + 1'b1;

  assign cmd_ready_o = (state_q == ST_IDLE) && !(ovalid_q && !out_o.ready);
  assign out_o.valid      = ovalid_q;
  assign out_o.run_valid  = res_q.run_valid;
  assign out_o.run_id     = res_q.run_id;
  assign out_o.done_valid = res_q.done_valid;
  assign out_o.done_time  = res_q.done_time;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (cmd_valid_i && cmd_ready_o) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      tick_q      <= '0;
      ovalid_q    <= 1'b0;
      for (int l = 0; l < NumLevels; l++) begin
        head_q[l]  <= '0;
        count_q[l] <= '0;
      end
      for (int t = 0; t < MaxTasks; t++) begin
        served_q[t] <= '0;
        level_q[t]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      if (state_q == ST_EXEC) begin
        if (do_pop) begin
          head_q[top_lvl] <= head_nx;
        end
        for (int l = 0; l < NumLevels; l++) begin
          if (push_ok && push_lvl == LvlW'(l)) begin
            count_q[l] <= push_cnt + 1'b1;
          end else if (do_pop && top_lvl == LvlW'(l)) begin
            count_q[l] <= count_q[l] - 1'b1;
          end
        end
        if (cmd_q.kind == KIND_ARRIVE) begin
          if (id_ok) begin
            served_q[SlotW'(cmd_q.task_id)] <= '0;
            level_q[SlotW'(cmd_q.task_id)]  <= '0;
          end
        end else begin
          tick_q   <= tick_q + 1'b1;
          ovalid_q <= 1'b1;
          if (do_push) level_q[cur_q] <= dem_lvl;
          if (serve) begin
            cur_q            <= new_cur;
            cur_valid_q      <= 1'b1;
            served_q[new_cur] <= served_nx;
          end else begin
            cur_q       <= '0;
            cur_valid_q <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_valid_i && cmd_ready_o) cmd_q <= cmd_i;
    if (state_q == ST_EXEC && cmd_q.kind == KIND_ARRIVE && id_ok) begin
      needed_q[SlotW'(cmd_q.task_id)] <= cmd_q.service_len;
    end
    if (state_q == ST_EXEC && cmd_q.kind == KIND_TICK) begin
      res_q.run_valid  <= serve;
      res_q.run_id     <= serve ? IdW'(new_cur) : '0;
      res_q.done_valid <= serve && (served_nx == needed_q[new_cur]);
      res_q.done_time  <= (serve && (served_nx == needed_q[new_cur])) ?
                          tick_q + 1'b1 : '0;
    end
  end
endmodule

// ===== hdl/feedback_queue_scheduler.sv =====
`timescale 1ns / 1ps
// Feedback scheduler with NumLevels FIFO levels and a one-tick quantum. Arrivals
// queue a task at level zero and give no transaction; every tick gives one. A
// two-entry queue takes items while the scheduler core works. The core handles
// each item in three steps (issue, registered level-memory read, update) and
// takes no new item until the last is done, nor while a result waits on out_o.ready.
module feedback_queue_scheduler import fqs_pkg::*; #(
  parameter int unsigned NumLevels = NumLevelsDef,
  parameter int unsigned MaxTasks  = MaxTasksDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  fqs_in_if.sink    in_i,
  fqs_out_if.source out_o
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  fqs_front u_front (
    .clk_i, .rst_ni, .in_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready)
  );

  fqs_back #(.NumLevels(NumLevels), .MaxTasks(MaxTasks)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready), .out_o
  );

  a_done_has_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.done_valid |-> out_o.run_valid)
    else $error("completion without a served task");
  a_no_cmd_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_ready && !cmd_valid |=> !$rose(out_o.valid))
    else $error("result without a command");
endmodule
